[design/pe2m_pkg.sv]
// shared types, constants and note tables for the pad event to midi encoder
package pe2m_pkg;

  // event counts and flag store size
  localparam int PadCount    = 48;
  localparam int ButtonCount = 4;
  localparam int NoteSlots   = 128;
  localparam int HoneyCount  = 48;

  // flag store: pad notes in the lower half, button notes in the upper half
  localparam int FlagWidth = 2;
  localparam int FlagDepth = 2 * NoteSlots;
  localparam int FlagAddrW = $clog2(FlagDepth);

  // event function codes
  localparam logic [2:0] FuncPad    = 3'd0;
  localparam logic [2:0] FuncPadVel = 3'd1;
  localparam logic [2:0] FuncBtn    = 3'd2;
  localparam logic [2:0] FuncBtnVel = 3'd3;
  localparam logic [2:0] FuncSlider = 3'd4;

  // pad layout codes
  localparam logic [1:0] LayoutPiano     = 2'd0;
  localparam logic [1:0] LayoutChromatic = 2'd1;
  localparam logic [1:0] LayoutHoneycomb = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CfgUseVelocity    = 3'd0;
  localparam logic [2:0] CfgPadLayout      = 3'd1;
  localparam logic [2:0] CfgBasePadNote    = 3'd2;
  localparam logic [2:0] CfgBaseButtonNote = 3'd3;
  localparam logic [2:0] CfgPadChannel     = 3'd4;
  localparam logic [2:0] CfgButtonChannel  = 3'd5;
  localparam logic [2:0] CfgSliderZero     = 3'd6;
  localparam logic [2:0] CfgSliderOne      = 3'd7;

  // midi status nibbles and fixed values
  localparam logic [3:0] StatusNoteOff = 4'h8;
  localparam logic [3:0] StatusNoteOn  = 4'h9;
  localparam logic [3:0] StatusCtrl    = 4'hB;
  localparam logic [7:0] GateVelocity  = 8'd100;
  localparam logic [15:0] SliderIdle   = 16'hFFFF;
  localparam logic [11:0] SliderRound  = 12'd2048;

  // piano offsets within one block of 16 pads: {no note, semitone offset}
  localparam logic [4:0] PianoOffset [16] = '{
    5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd12,
    5'd1, 5'd3, 5'h10, 5'd6, 5'd8, 5'd10, 5'h10, 5'h10
  };

  // honeycomb note table, entries past the last pad are never used
  localparam logic [6:0] HoneyNote [64] = '{
    7'd32, 7'd35, 7'd38, 7'd53, 7'd56, 7'd59, 7'd62, 7'd77,
    7'd40, 7'd43, 7'd46, 7'd61, 7'd64, 7'd67, 7'd70, 7'd85,
    7'd24, 7'd36, 7'd39, 7'd54, 7'd57, 7'd60, 7'd75, 7'd78,
    7'd41, 7'd44, 7'd47, 7'd62, 7'd65, 7'd68, 7'd71, 7'd86,
    7'd34, 7'd37, 7'd52, 7'd55, 7'd58, 7'd73, 7'd76, 7'd79,
    7'd42, 7'd45, 7'd48, 7'd63, 7'd66, 7'd69, 7'd72, 7'd87,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  typedef enum logic [1:0] {
    KindPad,
    KindBtn,
    KindSlider
  } kind_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  event_id;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       led_update;
    logic       led_is_button;
    logic [5:0] led_index;
    logic       led_on;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        use_velocity;
    logic [1:0]  pad_layout;
    logic [6:0]  base_pad_note;
    logic [6:0]  base_button_note;
    logic [3:0]  pad_channel;
    logic [3:0]  button_channel;
    logic [10:0] slider_zero_route;
    logic [10:0] slider_one_route;
  } cfg_t;

  // decoded event headed for the flag stage
  typedef struct packed {
    logic        vld;
    kind_e       kind;
    logic [6:0]  note;
    logic [5:0]  id;
    logic [15:0] value;
    logic [10:0] route;
  } dec_t;

  // one full three byte message
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       led_update;
    logic       led_is_button;
    logic [5:0] led_index;
    logic       led_on;
  } msg_t;

  // flag store write port
  typedef struct packed {
    logic                 we;
    logic [FlagAddrW-1:0] addr;
    logic [FlagWidth-1:0] data;
  } flag_wr_t;

endpackage

[design/pad_event_to_midi_encoder_unit.sv]
// top level of the pad, button and slider event to midi byte encoder
//
//  channel  direction  handshake              beat
//  in       input      in_valid_i / in_stall_o    one controller event
//  out      output     out_valid_o / out_stall_i  one midi byte with led info
//  cfg      input      cfg_valid_i / cfg_ready_o  one register write
//
// an event is decoded on entry and its note flags are read from a 256 x 2 ram;
// the next cycle the flag stage forwards the last write and, as it advances,
// writes the shifted flags back and hands any three byte message to the output
// buffer, which sends one byte a cycle while out_stall_i is low; the serializer
// sets the event rate. after reset a sweep clears the flag ram while in_stall_o
// stays high. a stalled output holds the buffer, the flag stage, then the input.
module pad_event_to_midi_encoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pe2m_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pe2m_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i
);
  import pe2m_pkg::*;

  cfg_t                 cfg_q;
  dec_t                 dec;
  logic                 take;
  logic                 s1_free;
  logic                 clearing;
  logic                 buf_free;
  logic                 msg_vld;
  msg_t                 msg;
  flag_wr_t             wr;
  logic [FlagWidth-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        use_velocity:      1'b0,
        pad_layout:        LayoutChromatic,
        base_pad_note:     7'd36,
        base_button_note:  7'd0,
        pad_channel:       4'd0,
        button_channel:    4'd0,
        slider_zero_route: 11'd0,
        slider_one_route:  11'd0
      };
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgUseVelocity:    cfg_q.use_velocity      <= cfg_data_i[0];
        CfgPadLayout:      cfg_q.pad_layout        <= cfg_data_i[1:0];
        CfgBasePadNote:    cfg_q.base_pad_note     <= cfg_data_i[6:0];
        CfgBaseButtonNote: cfg_q.base_button_note  <= cfg_data_i[6:0];
        CfgPadChannel:     cfg_q.pad_channel       <= cfg_data_i[3:0];
        CfgButtonChannel:  cfg_q.button_channel    <= cfg_data_i[3:0];
        CfgSliderZero:     cfg_q.slider_zero_route <= cfg_data_i;
        CfgSliderOne:      cfg_q.slider_one_route  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = clearing || !s1_free;
  assign take       = in_valid_i && !in_stall_o;

  pe2m_decode u_decode (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .dec_o  (dec)
  );

  // flag store, read issued as the event is taken
  pe2m_ram #(
    .Width (FlagWidth),
    .Depth (FlagDepth)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (take),
    .raddr_i ({dec.kind == KindBtn, dec.note}),
    .rdata_o (rdata)
  );

  pe2m_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dec_i      (dec),
    .take_i     (take),
    .cfg_i      (cfg_q),
    .rdata_i    (rdata),
    .buf_free_i (buf_free),
    .free_o     (s1_free),
    .clearing_o (clearing),
    .msg_vld_o  (msg_vld),
    .msg_o      (msg),
    .wr_o       (wr)
  );

  pe2m_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (msg_vld && buf_free),
    .msg_i       (msg),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/pe2m_ram.sv]
// generic single write port ram with registered read
module pe2m_ram #(
  parameter int Width = 2,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, returns old data on a same address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pe2m_decode.sv]
// event decode: note mapping, range checks and slider route selection
module pe2m_decode (
  input  pe2m_pkg::in_item_t item_i,
  input  pe2m_pkg::cfg_t     cfg_i,
  output pe2m_pkg::dec_t     dec_o
);
  import pe2m_pkg::*;

  logic [7:0] pad_note;
  logic       pad_hit;
  logic [4:0] piano_off;
  logic [7:0] btn_note;
  logic       pad_in_range;
  logic       btn_in_range;
  logic       pad_mode_ok;
  logic       btn_mode_ok;

  assign piano_off = PianoOffset[item_i.event_id[3:0]];

  // pad index to note by layout
  always_comb begin
    pad_note = '0;
    pad_hit  = 1'b0;
    unique case (cfg_i.pad_layout)
      LayoutChromatic: begin
        pad_note = {1'b0, cfg_i.base_pad_note} + {2'b00, item_i.event_id};
        pad_hit  = 1'b1;
      end
      LayoutPiano: begin
        pad_note = {1'b0, cfg_i.base_pad_note}
                 + {3'b000, item_i.event_id[5:4], 3'b000}
                 + {4'b0000, item_i.event_id[5:4], 2'b00}
                 + {4'b0000, piano_off[3:0]};
        pad_hit  = !piano_off[4];
      end
      LayoutHoneycomb: begin
        pad_note = {1'b0, HoneyNote[item_i.event_id]};
        pad_hit  = {1'b0, item_i.event_id} < 7'(HoneyCount);
      end
      default: begin
        pad_note = '0;
        pad_hit  = 1'b0;
      end
    endcase
  end

  assign btn_note     = {1'b0, cfg_i.base_button_note} + {2'b00, item_i.event_id};
  assign pad_in_range = {1'b0, item_i.event_id} < 7'(PadCount);
  assign btn_in_range = {1'b0, item_i.event_id} < 7'(ButtonCount);
  assign pad_mode_ok  = (item_i.func == FuncPadVel) == cfg_i.use_velocity;
  assign btn_mode_ok  = (item_i.func == FuncBtnVel) == cfg_i.use_velocity;

  // event classification
  always_comb begin
    dec_o       = '0;
    dec_o.id    = item_i.event_id;
    dec_o.value = item_i.value;
    dec_o.route = item_i.event_id[0] ? cfg_i.slider_one_route : cfg_i.slider_zero_route;
    unique case (item_i.func) inside
      FuncPad, FuncPadVel: begin
        dec_o.kind = KindPad;
        dec_o.note = pad_note[6:0];
        dec_o.vld  = pad_mode_ok && pad_in_range && pad_hit && !pad_note[7];
      end
      FuncBtn, FuncBtnVel: begin
        dec_o.kind = KindBtn;
        dec_o.note = btn_note[6:0];
        dec_o.vld  = btn_mode_ok && btn_in_range && !btn_note[7];
      end
      FuncSlider: begin
        dec_o.kind = KindSlider;
        dec_o.vld  = (item_i.event_id[5:1] == 5'd0) && (item_i.value != SliderIdle);
      end
      default: begin
        dec_o.vld = 1'b0;
      end
    endcase
  end

endmodule

[design/pe2m_update.sv]
// flag stage: read data forwarding, flag write back, message build, store clearing
module pe2m_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pe2m_pkg::dec_t                       dec_i,
  input  logic                                 take_i,
  input  pe2m_pkg::cfg_t                       cfg_i,
  input  logic [pe2m_pkg::FlagWidth-1:0]       rdata_i,
  input  logic                                 buf_free_i,
  output logic                                 free_o,
  output logic                                 clearing_o,
  output logic                                 msg_vld_o,
  output pe2m_pkg::msg_t                       msg_o,
  output pe2m_pkg::flag_wr_t                   wr_o
);
  import pe2m_pkg::*;

  logic                 s1_vld_q, s1_vld_d;
  dec_t                 s1_q;
  logic                 wt_vld_q;
  logic [FlagAddrW-1:0] wt_addr_q;
  logic [FlagWidth-1:0] wt_data_q;
  logic [FlagAddrW:0]   clr_cnt_q;

  logic [FlagAddrW-1:0] addr;
  logic [FlagWidth-1:0] flags;
  logic                 is_note;
  logic                 nz;
  logic                 send;
  logic                 adv;
  logic [3:0]           channel;
  logic [23:0]          slider_sum;
  logic [6:0]           cc;
  logic [6:0]           vel;

  assign clearing_o = !clr_cnt_q[FlagAddrW];

  // clearing sweep over the flag store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing_o) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign addr    = {s1_q.kind == KindBtn, s1_q.note};
  assign is_note = s1_q.kind != KindSlider;
  assign nz      = |s1_q.value;
  assign channel = (s1_q.kind == KindBtn) ? cfg_i.button_channel : cfg_i.pad_channel;

  // forward the most recent write when it hit this entry
  assign flags = (wt_vld_q && wt_addr_q == addr) ? wt_data_q : rdata_i;

  // slider scaling: value * 127 divided by 4096, rounded to nearest, saturated at 127
  assign slider_sum = {1'b0, s1_q.value, 7'd0} - {8'd0, s1_q.value} + {12'd0, SliderRound};
  assign cc  = (|slider_sum[23:19]) ? 7'd127 : slider_sum[18:12];
  assign vel = (|s1_q.value[15:7]) ? 7'd127 : s1_q.value[6:0];

  // message build
  always_comb begin
    msg_o = '0;
    send  = 1'b0;
    if (!is_note) begin
      send     = 1'b1;
      msg_o.b0 = {StatusCtrl, s1_q.route[10:7]};
      msg_o.b1 = {1'b0, s1_q.route[6:0]};
      msg_o.b2 = {1'b0, cc};
    end else begin
      msg_o.b1            = {1'b0, s1_q.note};
      msg_o.led_update    = 1'b1;
      msg_o.led_is_button = s1_q.kind == KindBtn;
      msg_o.led_index     = s1_q.id;
      if (cfg_i.use_velocity) begin
        send         = 1'b1;
        msg_o.b0     = {StatusNoteOn, channel};
        msg_o.b2     = {1'b0, vel};
        msg_o.led_on = nz;
      end else if (!flags[1] && nz) begin
        send         = 1'b1;
        msg_o.b0     = {StatusNoteOn, channel};
        msg_o.b2     = GateVelocity;
        msg_o.led_on = 1'b1;
      end else if (!nz) begin
        send         = 1'b1;
        msg_o.b0     = {StatusNoteOff, channel};
        msg_o.b2     = 8'd0;
        msg_o.led_on = 1'b0;
      end
    end
  end

  assign adv       = s1_vld_q && (!send || buf_free_i);
  assign free_o    = !s1_vld_q || adv;
  assign msg_vld_o = s1_vld_q && send;

  // flag store write: sweep first, then shifted flags of each note event
  always_comb begin
    wr_o = '0;
    if (clearing_o) begin
      wr_o.we   = 1'b1;
      wr_o.addr = clr_cnt_q[FlagAddrW-1:0];
      wr_o.data = '0;
    end else begin
      wr_o.we   = adv && is_note;
      wr_o.addr = addr;
      wr_o.data = {flags[0], nz};
    end
  end

  // stage valid
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (take_i) begin
      s1_vld_d = dec_i.vld;
    end else if (adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      wt_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (wr_o.we) begin
        wt_vld_q <= 1'b1;
      end
    end
  end

  // stage payload and last write tracker
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_q <= dec_i;
    end
    if (wr_o.we) begin
      wt_addr_q <= wr_o.addr;
      wt_data_q <= wr_o.data;
    end
  end

endmodule

[design/pe2m_serializer.sv]
// output buffer that sends one message as three byte beats
module pe2m_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pe2m_pkg::msg_t      msg_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pe2m_pkg::out_item_t out_data_o
);
  import pe2m_pkg::*;

  localparam logic [1:0] ByteStatus = 2'd0;
  localparam logic [1:0] ByteNote   = 2'd1;
  localparam logic [1:0] ByteLast   = 2'd2;

  logic       vld_q;
  logic [1:0] idx_q;
  msg_t       msg_q;

  assign free_o      = !vld_q || (idx_q == ByteLast && !out_stall_i);
  assign out_valid_o = vld_q;

  // byte select
  always_comb begin
    out_data_o = '0;
    unique case (idx_q)
      ByteStatus: out_data_o.midi_byte = msg_q.b0;
      ByteNote:   out_data_o.midi_byte = msg_q.b1;
      ByteLast: begin
        out_data_o.midi_byte     = msg_q.b2;
        out_data_o.led_update    = msg_q.led_update;
        out_data_o.led_is_button = msg_q.led_update & msg_q.led_is_button;
        out_data_o.led_index     = msg_q.led_update ? msg_q.led_index : 6'd0;
        out_data_o.led_on        = msg_q.led_update & msg_q.led_on;
        out_data_o.last          = 1'b1;
      end
      default: out_data_o = '0;
    endcase
  end

  // beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= ByteStatus;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= ByteStatus;
    end else if (vld_q && !out_stall_i) begin
      if (idx_q == ByteLast) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
    end
  end

endmodule
